/* sv/lmse_pkg.sv */
package lmse_pkg;

  // Request modes
  typedef enum logic [2:0] {
    MODE_SET_MSG     = 3'd0,
    MODE_SET_DATA    = 3'd1,
    MODE_SET_DATA_ID = 3'd2,
    MODE_SET_STATUS  = 3'd3,
    MODE_REBUILD     = 3'd4,
    MODE_TICK        = 3'd5,
    MODE_READ        = 3'd6,
    MODE_READ_ID     = 3'd7
  } mode_t;

  // Result codes
  typedef enum logic [1:0] {
    RES_OK    = 2'd0,
    RES_EMPTY = 2'd1,
    RES_ERR   = 2'd2
  } res_code_t;

  // Message directions
  localparam logic [1:0] DIR_SEND = 2'd1;
  localparam logic [1:0] DIR_RECV = 2'd2;

  // Message status values
  localparam logic [1:0] STAT_NONE = 2'd0;
  localparam logic [1:0] STAT_SENT = 2'd1;
  localparam logic [1:0] STAT_RECV = 2'd2;

  // Slot content for "no message"
  localparam logic [3:0] EMPTY_SLOT = 4'd15;

  // Stride = period / PERIOD_UNIT, used only when 0 < stride < STRIDE_LIMIT
  localparam int unsigned PERIOD_UNIT  = 20;
  localparam int unsigned STRIDE_LIMIT = 100;

  // period / 20 = ((period >> 2) * 0xCCCD) >> 18, exact for 14-bit operands
  localparam int unsigned PER_SHIFT   = 2;
  localparam int unsigned PER_W       = 16;
  localparam int unsigned QIN_W       = PER_W - PER_SHIFT;
  localparam int unsigned RECIP_W     = 16;
  localparam logic [RECIP_W-1:0] RECIP5 = 16'hCCCD;
  localparam int unsigned RECIP_SHIFT = 18;
  localparam int unsigned PROD_W      = QIN_W + RECIP_W;
  localparam int unsigned STRIDE_W    = PROD_W - RECIP_SHIFT;
  localparam int unsigned STEP_W      = $clog2(STRIDE_LIMIT);

  // One message table entry
  typedef struct packed {
    logic [5:0]       ident;
    logic [1:0]       dir;
    logic [PER_W-1:0] period;
    logic [63:0]      payload;
    logic [1:0]       status;
  } msg_t;

  // One result
  typedef struct packed {
    res_code_t   code;
    logic        launch;
    logic        launch_receive;
    logic [5:0]  id;
    logic [63:0] data;
    logic [1:0]  status;
    logic        clr_tx;
    logic        clr_rx;
  } res_t;

  // Stride unit output
  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              usable;
  } stride_t;

endpackage

/* sv/lmse_stride.sv */
// Two-stage stride unit: reciprocal multiply, then range check.
module lmse_stride (
  input  logic                          clk,
  input  logic [lmse_pkg::PER_W-1:0]    period,
  output lmse_pkg::stride_t             stride
);

  logic [lmse_pkg::PROD_W-1:0]   prod;
  logic [lmse_pkg::STRIDE_W-1:0] quot;

  assign quot = prod[lmse_pkg::RECIP_SHIFT +: lmse_pkg::STRIDE_W];

  // stage 1: divide by 20 through the reciprocal of 5 on period / 4
  // stage 2: keep the low step bits and flag 0 < stride < limit
  always_ff @(posedge clk) begin
    prod <= lmse_pkg::PROD_W'(period[lmse_pkg::PER_W-1:lmse_pkg::PER_SHIFT])
          * lmse_pkg::PROD_W'(lmse_pkg::RECIP5);
    stride.step   <= quot[lmse_pkg::STEP_W-1:0];
    stride.usable <= (quot != '0)
                  && (quot < lmse_pkg::STRIDE_W'(lmse_pkg::STRIDE_LIMIT));
  end

endmodule

/* sv/lin_master_schedule_engine.sv */
// LIN master frame scheduler. One request is handled at a time; the result
// sits in an output register, so the next request is taken while it waits.
// Each table has a single read port, so set and read by id scan the messages
// one by one, and rebuild first clears the slot table, then reads each
// message in turn and fills the slots of each message with a usable stride.
// After reset the slot table is cleared to the empty marker; no request is
// accepted until this clearing is done.
module lin_master_schedule_engine #(
  parameter int unsigned MSG_COUNT  = 8,
  parameter int unsigned SLOT_COUNT = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [3:0]  slot,
  input  logic [5:0]  frame_id,
  input  logic [1:0]  direction,
  input  logic [15:0] period_ms,
  input  logic [63:0] payload,
  input  logic [1:0]  new_status,
  input  logic        tx_done,
  input  logic        rx_done,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_code,
  output logic        launch,
  output logic        launch_receive,
  output logic [5:0]  out_id,
  output logic [63:0] out_data,
  output logic [1:0]  out_status,
  output logic        clear_tx_flag,
  output logic        clear_rx_flag
);

  localparam int unsigned MAW = (MSG_COUNT > 1) ? $clog2(MSG_COUNT) : 1;
  localparam int unsigned SAW = $clog2(SLOT_COUNT);
  localparam int unsigned JW  = $clog2(SLOT_COUNT + lmse_pkg::STRIDE_LIMIT);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_ENT, S_SRCH_RD, S_SRCH_CMP,
    S_RB_CLR, S_RB_RD, S_RB_W1, S_RB_W2, S_RB_STRIDE, S_RB_FILL,
    S_TK_SLOT, S_TK_CLOSE, S_TK_ADV, S_TK_LSLOT, S_TK_LAUNCH, S_DONE
  } state_t;

  state_t state;

  // captured request
  lmse_pkg::mode_t req_mode;
  logic [3:0]      req_slot;
  logic [5:0]      req_id;
  logic [1:0]      req_dir;
  logic [15:0]     req_per;
  logic [63:0]     req_pay;
  logic [1:0]      req_nst;
  logic            req_txd;
  logic            req_rxd;

  lmse_pkg::res_t res;
  lmse_pkg::res_t out_q;

  logic [SAW-1:0] sweep;
  logic [SAW-1:0] cursor;
  logic [SAW-1:0] cursor_next;
  logic [MAW-1:0] kidx;
  logic [3:0]     start;
  logic [JW-1:0]  fill_j;
  logic [lmse_pkg::STEP_W-1:0] step_q;

  // message table
  lmse_pkg::msg_t msg_mem [MSG_COUNT];
  logic [MSG_COUNT-1:0] msg_vld;
  lmse_pkg::msg_t msg_rd;
  logic           msg_rd_vld;
  lmse_pkg::msg_t msg_ent;
  logic           msg_re;
  logic [MAW-1:0] msg_raddr;
  logic           msg_we;
  logic [MAW-1:0] msg_waddr;
  lmse_pkg::msg_t msg_wdata;

  // slot table
  logic [3:0]     slot_mem [SLOT_COUNT];
  logic [3:0]     slot_rd;
  logic           slot_re;
  logic [SAW-1:0] slot_raddr;
  logic           slot_we;
  logic [SAW-1:0] slot_waddr;
  logic [3:0]     slot_wdata;

  lmse_pkg::stride_t stride;

  logic req_ok;
  logic slot_hit;
  logic id_hit;
  logic last_k;

  assign in_ready    = (state == S_IDLE);
  assign msg_ent     = msg_rd_vld ? msg_rd : '0;
  assign req_ok      = (req_slot < 4'(MSG_COUNT));
  assign slot_hit    = (slot_rd < 4'(MSG_COUNT));
  assign id_hit      = (msg_ent.ident == req_id);
  assign last_k      = (kidx == MAW'(MSG_COUNT - 1));
  assign cursor_next = (cursor == SAW'(SLOT_COUNT - 1)) ? '0 : cursor + 1'b1;

  lmse_stride u_stride (
    .clk    (clk),
    .period (msg_ent.period),
    .stride (stride)
  );

  // message table storage, valid bits stand in for the zero reset
  always_ff @(posedge clk) begin
    if (rst) begin
      msg_vld <= '0;
    end else if (msg_we) begin
      msg_vld[msg_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (msg_we) begin
      msg_mem[msg_waddr] <= msg_wdata;
    end
    if (msg_re) begin
      msg_rd     <= msg_mem[msg_raddr];
      msg_rd_vld <= msg_vld[msg_raddr];
    end
  end

  // slot table storage
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd <= slot_mem[slot_raddr];
    end
  end

  // table access control
  always_comb begin
    msg_re     = 1'b0;
    msg_raddr  = kidx;
    msg_we     = 1'b0;
    msg_waddr  = kidx;
    msg_wdata  = msg_ent;
    slot_re    = 1'b0;
    slot_raddr = cursor;
    slot_we    = 1'b0;
    slot_waddr = sweep;
    slot_wdata = lmse_pkg::EMPTY_SLOT;
    unique case (state)
      S_INIT, S_RB_CLR: begin
        slot_we = 1'b1;
      end
      S_IDLE: begin
        // fetch the addressed entry and the current slot up front
        if (in_valid) begin
          msg_re    = (slot < 4'(MSG_COUNT));
          msg_raddr = slot[MAW-1:0];
          slot_re   = 1'b1;
        end
      end
      S_ENT: begin
        msg_waddr = req_slot[MAW-1:0];
        if (req_ok) begin
          unique case (req_mode)
            lmse_pkg::MODE_SET_MSG: begin
              msg_we            = 1'b1;
              msg_wdata.ident   = req_id;
              msg_wdata.dir     = req_dir;
              msg_wdata.period  = req_per;
              msg_wdata.payload = req_pay;
            end
            lmse_pkg::MODE_SET_DATA: begin
              msg_we            = 1'b1;
              msg_wdata.payload = req_pay;
            end
            lmse_pkg::MODE_SET_STATUS: begin
              msg_we           = 1'b1;
              msg_wdata.status = req_nst;
            end
            default: ;
          endcase
        end
      end
      S_SRCH_RD, S_RB_RD: begin
        msg_re = 1'b1;
      end
      S_SRCH_CMP: begin
        if (id_hit && req_mode == lmse_pkg::MODE_SET_DATA_ID) begin
          msg_we            = 1'b1;
          msg_wdata.payload = req_pay;
        end
      end
      S_RB_FILL: begin
        slot_waddr = fill_j[SAW-1:0];
        slot_wdata = 4'(kidx);
        slot_we    = (fill_j < JW'(SLOT_COUNT));
      end
      S_TK_SLOT, S_TK_LSLOT: begin
        msg_re    = slot_hit;
        msg_raddr = slot_rd[MAW-1:0];
      end
      S_TK_CLOSE: begin
        // close the slot that ends with this tick
        if (msg_ent.dir == lmse_pkg::DIR_SEND) begin
          msg_we           = 1'b1;
          msg_wdata.status = req_txd ? lmse_pkg::STAT_SENT : lmse_pkg::STAT_NONE;
        end else if (msg_ent.dir == lmse_pkg::DIR_RECV) begin
          msg_we = 1'b1;
          if (req_rxd) begin
            msg_wdata.payload = req_pay;
            msg_wdata.status  = lmse_pkg::STAT_RECV;
          end else begin
            msg_wdata.status  = lmse_pkg::STAT_NONE;
          end
        end
      end
      S_TK_ADV: begin
        slot_re    = 1'b1;
        slot_raddr = cursor_next;
      end
      S_RB_W1, S_RB_W2, S_RB_STRIDE, S_TK_LAUNCH, S_DONE: ;
    endcase
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      sweep     <= '0;
      cursor    <= SAW'(SLOT_COUNT - 1);
      out_valid <= 1'b0;
      kidx      <= '0;
      start     <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          if (sweep == SAW'(SLOT_COUNT - 1)) begin
            sweep <= '0;
            state <= S_IDLE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_mode <= lmse_pkg::mode_t'(mode);
            req_slot <= slot;
            req_id   <= frame_id;
            req_dir  <= direction;
            req_per  <= period_ms;
            req_pay  <= payload;
            req_nst  <= new_status;
            req_txd  <= tx_done;
            req_rxd  <= rx_done;
            res      <= '{code: lmse_pkg::RES_ERR, default: '0};
            kidx     <= '0;
            start    <= '0;
            unique case (lmse_pkg::mode_t'(mode))
              lmse_pkg::MODE_SET_MSG, lmse_pkg::MODE_SET_DATA,
              lmse_pkg::MODE_SET_STATUS, lmse_pkg::MODE_READ: state <= S_ENT;
              lmse_pkg::MODE_SET_DATA_ID, lmse_pkg::MODE_READ_ID: state <= S_SRCH_RD;
              lmse_pkg::MODE_REBUILD: state <= S_RB_CLR;
              lmse_pkg::MODE_TICK:    state <= S_TK_SLOT;
            endcase
          end
        end
        S_ENT: begin
          if (req_ok) begin
            res.code <= lmse_pkg::RES_OK;
            if (req_mode == lmse_pkg::MODE_READ) begin
              res.data   <= msg_ent.payload;
              res.status <= msg_ent.status;
            end
          end
          state <= S_DONE;
        end
        S_SRCH_RD: begin
          state <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          // lowest matching index wins
          if (id_hit) begin
            res.code <= lmse_pkg::RES_OK;
            if (req_mode == lmse_pkg::MODE_READ_ID) begin
              res.data <= msg_ent.payload;
            end
            state <= S_DONE;
          end else if (last_k) begin
            state <= S_DONE;
          end else begin
            kidx  <= kidx + 1'b1;
            state <= S_SRCH_RD;
          end
        end
        S_RB_CLR: begin
          if (sweep == SAW'(SLOT_COUNT - 1)) begin
            sweep <= '0;
            state <= S_RB_RD;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_RB_RD: begin
          state <= S_RB_W1;
        end
        S_RB_W1: begin
          state <= S_RB_W2;
        end
        S_RB_W2: begin
          state <= S_RB_STRIDE;
        end
        S_RB_STRIDE: begin
          if (stride.usable) begin
            fill_j <= JW'(start);
            step_q <= stride.step;
            state  <= S_RB_FILL;
          end else if (last_k) begin
            res.code <= lmse_pkg::RES_OK;
            state    <= S_DONE;
          end else begin
            kidx  <= kidx + 1'b1;
            state <= S_RB_RD;
          end
        end
        S_RB_FILL: begin
          if (fill_j < JW'(SLOT_COUNT)) begin
            fill_j <= fill_j + JW'(step_q);
          end else begin
            start <= start + 4'd1;
            if (last_k) begin
              res.code <= lmse_pkg::RES_OK;
              state    <= S_DONE;
            end else begin
              kidx  <= kidx + 1'b1;
              state <= S_RB_RD;
            end
          end
        end
        S_TK_SLOT: begin
          kidx  <= slot_rd[MAW-1:0];
          state <= slot_hit ? S_TK_CLOSE : S_TK_ADV;
        end
        S_TK_CLOSE: begin
          if (msg_ent.dir == lmse_pkg::DIR_SEND) begin
            res.clr_tx <= req_txd;
          end else if (msg_ent.dir == lmse_pkg::DIR_RECV) begin
            res.clr_rx <= req_rxd;
          end
          state <= S_TK_ADV;
        end
        S_TK_ADV: begin
          cursor <= cursor_next;
          state  <= S_TK_LSLOT;
        end
        S_TK_LSLOT: begin
          if (slot_hit) begin
            state <= S_TK_LAUNCH;
          end else begin
            res.code <= lmse_pkg::RES_EMPTY;
            state    <= S_DONE;
          end
        end
        S_TK_LAUNCH: begin
          // launch the new slot's frame
          if (msg_ent.dir == lmse_pkg::DIR_SEND) begin
            res.code           <= lmse_pkg::RES_OK;
            res.launch         <= 1'b1;
            res.launch_receive <= 1'b0;
            res.id             <= msg_ent.ident;
            res.data           <= msg_ent.payload;
          end else if (msg_ent.dir == lmse_pkg::DIR_RECV) begin
            res.code           <= lmse_pkg::RES_OK;
            res.launch         <= 1'b1;
            res.launch_receive <= 1'b1;
            res.id             <= msg_ent.ident;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_q     <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign result_code    = out_q.code;
  assign launch         = out_q.launch;
  assign launch_receive = out_q.launch_receive;
  assign out_id         = out_q.id;
  assign out_data       = out_q.data;
  assign out_status     = out_q.status;
  assign clear_tx_flag  = out_q.clr_tx;
  assign clear_rx_flag  = out_q.clr_rx;

  // one request in flight at a time
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  // message writes stay inside the table
  a_msg_addr: assert property (@(posedge clk) disable iff (rst)
    msg_we |-> (msg_waddr <= MAW'(MSG_COUNT - 1)))
    else $error("message write beyond table");

  // slot table is written only by clearing and rebuild fill
  a_slot_write: assert property (@(posedge clk) disable iff (rst)
    slot_we |-> (state == S_INIT || state == S_RB_CLR || state == S_RB_FILL))
    else $error("slot write outside rebuild");

  // cursor stays inside the schedule
  a_cursor: assert property (@(posedge clk) disable iff (rst)
    cursor <= SAW'(SLOT_COUNT - 1))
    else $error("cursor out of range");

  // a launched frame always reports success
  a_launch_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && launch |-> (out_q.code == lmse_pkg::RES_OK))
    else $error("launch without success code");

endmodule
